// ===== design/cht_pkg.sv =====
// shared constants and types for the chained hash table
// no dependencies; imported by cht_mod_unit, chained_hash_table_insert_lookup and the testbench files
package cht_pkg;

    localparam int KEY_W    = 31;
    localparam int PAY_W    = 16;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

endpackage

// ===== design/cht_mod_unit.sv =====
// key modulo bucket count: the low key bits for a power of two, else a reciprocal multiply
// depends on cht_pkg
module cht_mod_unit #(
    parameter int N = 64,
    localparam int RW = (N > 1) ? $clog2(N) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cht_pkg::KEY_W-1:0] i_value,
    output logic                      o_done,
    output logic [RW-1:0]             o_rem
);
    import cht_pkg::*;

    generate
        if ((N & (N - 1)) == 0) begin : g_pow2
            logic          r_done;
            logic [RW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_rem <= i_value[RW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_recip
            // floor(key / N) as (key * MUL) >> SH, exact for every key below 2**KEY_W
            localparam int SH = KEY_W + RW;
            localparam int PW = KEY_W + 32;
            localparam logic [31:0] MUL =
                32'(((64'd1 << SH) + 64'(N) - 64'd1) / 64'(N));

            logic [KEY_W-1:0] r_val;
            logic [KEY_W-1:0] r_quo;
            logic [RW-1:0]    r_rem;
            logic [1:0]       r_pipe;
            logic             r_done;
            logic [PW-1:0]    prod;

            assign prod = PW'(r_val) * PW'(MUL);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pipe <= '0;
                    r_done <= 1'b0;
                end else begin
                    r_pipe <= {r_pipe[0], i_start};
                    r_done <= r_pipe[1];
                end
                if (i_start) begin
                    r_val <= i_value;
                end
                if (r_pipe[0]) begin
                    r_quo <= KEY_W'(prod >> SH);
                end
                // remainder is exact, always below N
                if (r_pipe[1]) begin
                    r_rem <= RW'(r_val - r_quo * KEY_W'(N));
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

// ===== design/chained_hash_table_insert_lookup.sv =====
// chained hash table top level: bucket count memory, entry memory and the walk sequencer
// depends on cht_pkg and cht_mod_unit
//
// Key/payload table with separate chaining. Each input beat is an insert or a lookup;
// the bucket is key modulo NUM_BUCKETS and each bucket holds up to BUCKET_DEPTH entries
// kept in ascending key order (duplicates kept, an insert equal to the head lands right
// after it). Lookups return the payload of the first matching entry; an insert into a
// full bucket is dropped and reported with bucket_full. Every input beat gives exactly
// one output beat. Items are handled one at a time: each passes the key reduction, the
// bucket count read and, where one is needed, a walk over the bucket's entries (a lookup
// walks from the head up to the match, an insert walks from the tail down to its slot,
// moving each entry it passes up by one), one more step when an insert lands at the head
// of a nonempty bucket, and hands its result over once the output register has drained.
// The walk is set by the single read port of the entry memory, one entry per cycle.
// After reset the bucket count memory is swept to zero with the input stalled.
// A finished result sits in the output register while the next input beat is taken.
module chained_hash_table_insert_lookup #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    input  logic [cht_pkg::PAY_W-1:0] i_payload,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [cht_pkg::PAY_W-1:0] o_payload_out,
    output logic                      o_bucket_full
);
    import cht_pkg::*;

    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(BUCKET_DEPTH + 1);
    localparam int EW    = KEY_W + PAY_W;

    typedef enum logic [2:0] {
        S_CLEAR,  // zero the bucket counts after reset
        S_IDLE,   // wait for an input beat
        S_HASH,   // key reduction to a bucket, count read issued when done
        S_CNT,    // bucket count available, start the walk or go to the result
        S_WALK,   // one entry per cycle
        S_PUT,    // insert at the head after moving every entry
        S_RES     // hand the result to the output register
    } t_state;

    t_state          r_state;
    logic [BW-1:0]   r_clr;
    t_kind           r_kind;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic [BW-1:0]   r_bucket;
    logic [AW-1:0]   r_base;
    logic [CW-1:0]   r_j;
    logic            r_res_found;
    logic [PAY_W-1:0] r_res_pay;
    logic            r_res_full;
    logic            r_o_valid;
    logic            r_o_found;
    logic [PAY_W-1:0] r_o_pay;
    logic            r_o_full;

    // memories and their read registers
    logic [CW-1:0]   cnt_mem [NUM_BUCKETS];
    logic [EW-1:0]   ent_mem [SLOTS];
    logic [CW-1:0]   r_cnt_q;
    logic [EW-1:0]   r_rd_data;

    // memory port controls
    logic            cr_en;
    logic            cw_en;
    logic [BW-1:0]   cw_addr;
    logic [CW-1:0]   cw_data;
    logic            er_en;
    logic [AW-1:0]   er_addr;
    logic            ew_en;
    logic [AW-1:0]   ew_addr;
    logic [EW-1:0]   ew_data;

    logic            mod_start;
    logic            mod_done;
    logic [BW-1:0]   mod_rem;

    logic [KEY_W-1:0] rd_key;
    logic            rd_match;
    logic            rd_move;
    logic            accept;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign mod_start  = accept;
    assign o_in_stall = (r_state != S_IDLE);

    assign o_out_valid   = r_o_valid;
    assign o_found       = r_o_found;
    assign o_payload_out = r_o_pay;
    assign o_bucket_full = r_o_full;

    cht_mod_unit #(
        .N (NUM_BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign rd_key   = r_rd_data[EW-1:PAY_W];
    assign rd_match = (rd_key == r_key);
    // entry stays ahead of the new key: head moves only if strictly greater
    assign rd_move  = (r_j == '0) ? (rd_key > r_key) : (rd_key >= r_key);

    // memory port controls from the sequencer state
    always_comb begin
        cr_en   = 1'b0;
        cw_en   = 1'b0;
        cw_addr = r_bucket;
        cw_data = r_cnt_q + CW'(1);
        er_en   = 1'b0;
        er_addr = r_base + AW'(r_j);
        ew_en   = 1'b0;
        ew_addr = r_base + AW'(r_j + CW'(1));
        ew_data = {r_key, r_pay};
        unique case (r_state)
            S_CLEAR: begin
                cw_en   = 1'b1;
                cw_addr = r_clr;
                cw_data = '0;
            end
            S_HASH: begin
                cr_en = mod_done;
            end
            S_CNT: begin
                if (r_kind == KIND_INSERT) begin
                    if (r_cnt_q == '0) begin
                        ew_en   = 1'b1;
                        ew_addr = r_base;
                        cw_en   = 1'b1;
                    end else if (r_cnt_q < CW'(BUCKET_DEPTH)) begin
                        er_en   = 1'b1;
                        er_addr = r_base + AW'(r_cnt_q - CW'(1));
                    end
                end else if (r_cnt_q != '0) begin
                    er_en   = 1'b1;
                    er_addr = r_base;
                end
            end
            S_WALK: begin
                if (r_kind == KIND_INSERT) begin
                    ew_en = 1'b1;
                    if (rd_move) begin
                        ew_data = r_rd_data;
                        if (r_j != '0) begin
                            er_en   = 1'b1;
                            er_addr = r_base + AW'(r_j - CW'(1));
                        end
                    end else begin
                        cw_en = 1'b1;
                    end
                end else if (!rd_match && (r_j + CW'(1) != r_cnt_q)) begin
                    er_en   = 1'b1;
                    er_addr = r_base + AW'(r_j + CW'(1));
                end
            end
            S_PUT: begin
                ew_en   = 1'b1;
                ew_addr = r_base;
                cw_en   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // bucket count memory
    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            cnt_mem[cw_addr] <= cw_data;
        end
        if (cr_en) begin
            r_cnt_q <= cnt_mem[mod_rem];
        end
    end

    // entry memory, key above payload
    always_ff @(posedge i_clk) begin
        if (ew_en) begin
            ent_mem[ew_addr] <= ew_data;
        end
        if (er_en) begin
            r_rd_data <= ent_mem[er_addr];
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // in S_RES the output register is reloaded below whenever it drains
            if (r_o_valid && !i_out_stall && (r_state != S_RES)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= t_kind'(i_kind);
                        r_key   <= i_key;
                        r_pay   <= i_payload;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (mod_done) begin
                        r_bucket <= mod_rem;
                        r_base   <= AW'(mod_rem) * AW'(BUCKET_DEPTH);
                        r_state  <= S_CNT;
                    end
                end
                S_CNT: begin
                    r_res_found <= 1'b0;
                    r_res_pay   <= '0;
                    r_res_full  <= 1'b0;
                    if (r_kind == KIND_INSERT) begin
                        if (r_cnt_q >= CW'(BUCKET_DEPTH)) begin
                            r_res_full <= 1'b1;
                            r_state    <= S_RES;
                        end else if (r_cnt_q == '0) begin
                            r_state <= S_RES;
                        end else begin
                            r_j     <= r_cnt_q - CW'(1);
                            r_state <= S_WALK;
                        end
                    end else begin
                        if (r_cnt_q == '0) begin
                            r_state <= S_RES;
                        end else begin
                            r_j     <= '0;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_kind == KIND_INSERT) begin
                        if (rd_move) begin
                            if (r_j == '0) begin
                                r_state <= S_PUT;
                            end else begin
                                r_j <= r_j - CW'(1);
                            end
                        end else begin
                            r_state <= S_RES;
                        end
                    end else begin
                        if (rd_match) begin
                            r_res_found <= 1'b1;
                            r_res_pay   <= r_rd_data[PAY_W-1:0];
                            r_state     <= S_RES;
                        end else if (r_j + CW'(1) == r_cnt_q) begin
                            r_state <= S_RES;
                        end else begin
                            r_j <= r_j + CW'(1);
                        end
                    end
                end
                S_PUT: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_found <= r_res_found;
                        r_o_pay   <= r_res_pay;
                        r_o_full  <= r_res_full;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/cht_table_checker.sv =====
// scoreboard for the chained hash table: watches both channels, keeps its own table model
// and compares every output beat with the oldest predicted reply; depends on cht_pkg
module cht_table_checker #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_kind,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    input  logic [cht_pkg::PAY_W-1:0] i_payload,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_found,
    input  logic [cht_pkg::PAY_W-1:0] i_payload_out,
    input  logic                      i_bucket_full,
    output int                        o_fail_count,
    output int                        o_pending
);
    import cht_pkg::*;

    typedef struct packed {
        logic             found;
        logic [PAY_W-1:0] payload;
        logic             full;
    } t_table_reply;

    logic [KEY_W-1:0] slot_key [NUM_BUCKETS][BUCKET_DEPTH];
    logic [PAY_W-1:0] slot_pay [NUM_BUCKETS][BUCKET_DEPTH];
    int               fill     [NUM_BUCKETS];
    t_table_reply     reply_q  [$];
    int               mismatch_count = 0;
    int               pending_beats  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_beats;

    // applies one insert or lookup to the model table and returns the reply it gives
    function automatic t_table_reply run_table_op(input t_kind kind,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PAY_W-1:0] pay);
        t_table_reply r;
        int b, cnt, pos, i;
        r   = '0;
        b   = int'({1'b0, key} % NUM_BUCKETS);
        cnt = fill[b];
        if (kind == KIND_INSERT) begin
            if (cnt >= BUCKET_DEPTH) begin
                r.full = 1'b1;
            end else begin
                // head unless the head key is not above the new key
                pos = 0;
                if (cnt != 0 && slot_key[b][0] <= key) begin
                    pos = 1;
                    while (pos < cnt && slot_key[b][pos] < key) pos++;
                end
                for (i = cnt; i > pos; i--) begin
                    slot_key[b][i] = slot_key[b][i-1];
                    slot_pay[b][i] = slot_pay[b][i-1];
                end
                slot_key[b][pos] = key;
                slot_pay[b][pos] = pay;
                fill[b]          = cnt + 1;
            end
        end else begin
            for (i = 0; i < cnt && !r.found; i++) begin
                if (slot_key[b][i] == key) begin
                    r.found   = 1'b1;
                    r.payload = slot_pay[b][i];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_table_reply want;
        if (!i_rst_n) begin
            foreach (fill[b]) fill[b] = 0;
            reply_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                reply_q.push_back(run_table_op(t_kind'(i_kind), i_key, i_payload));
            if (i_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("output beat with no reply pending", 0, 1);
                end else begin
                    want = reply_q.pop_front();
                    if (i_found !== want.found)
                        report_mismatch("found", want.found, i_found);
                    if (i_payload_out !== want.payload)
                        report_mismatch("payload_out", want.payload, i_payload_out);
                    if (i_bucket_full !== want.full)
                        report_mismatch("bucket_full", want.full, i_bucket_full);
                end
            end
        end
        pending_beats <= reply_q.size();
    end

endmodule

// ===== tb/sv/tb_chained_hash_table_insert_lookup.sv =====
// top of the chained hash table testbench: clock, reset, stimulus and the verdict
// depends on cht_pkg, chained_hash_table_insert_lookup and cht_table_checker
module tb_chained_hash_table_insert_lookup;
    import cht_pkg::*;

    localparam int NUM_BUCKETS  = 64;
    localparam int BUCKET_DEPTH = 8;
    localparam int RANDOM_OPS   = 1400;
    // worst item: sender gap, block time and receiver stall, plus the two
    // long hold-offs and the count sweep after reset; taken several times over
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF     = 300;
    // bucket that the directed part fills to the brim
    localparam int unsigned DIR_BUCKET = 5;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_kind;
    logic [KEY_W-1:0] i_key;
    logic [PAY_W-1:0] i_payload;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_found;
    logic [PAY_W-1:0] o_payload_out;
    logic             o_bucket_full;

    int               fail_count;
    int               pending;
    int               cycle_count;
    logic [KEY_W-1:0] stored_keys [$];   // keys offered for insert, reused for lookups and repeat inserts
    bit               sender_calm   = 1'b0;
    bit               receiver_calm = 1'b0;

    chained_hash_table_insert_lookup #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_payload_out (o_payload_out),
        .o_bucket_full (o_bucket_full)
    );

    cht_table_checker #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_table_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_found       (o_found),
        .i_payload_out (o_payload_out),
        .i_bucket_full (o_bucket_full),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // key in the directed bucket, ordered by its upper part
    function automatic logic [KEY_W-1:0] chain_key(input int unsigned upper);
        return KEY_W'(upper * NUM_BUCKETS + DIR_BUCKET);
    endfunction

    // key in one of the top eight buckets, so those fill up and overflow;
    // half the time the upper bits are tiny so equal and neighboring keys collide
    function automatic logic [KEY_W-1:0] crowded_key();
        int unsigned upper;
        int unsigned b;
        upper = $urandom_range(0, 1) ? $urandom_range(0, 3) : ($urandom & 32'h01FF_FFFF);
        b     = $urandom_range(NUM_BUCKETS - 8, NUM_BUCKETS - 1);
        return KEY_W'(upper * NUM_BUCKETS + b);
    endfunction

    // one input beat: optional idle gap, then hold valid until the block takes it
    task automatic offer_beat(input t_kind kind, input logic [KEY_W-1:0] key,
                              input logic [PAY_W-1:0] pay);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_payload  <= pay;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (kind == KIND_INSERT) stored_keys.push_back(key);
    endtask

    // inserts that crowd buckets or repeat keys, lookups mostly of keys already
    // offered or of crowded keys; the rest is keys spread over the whole range
    task automatic offer_random_op();
        t_kind            kind;
        logic [KEY_W-1:0] key;
        int               pick;
        kind = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_LOOKUP;
        pick = $urandom_range(0, 99);
        if (kind == KIND_INSERT) begin
            if (pick < 30)
                key = crowded_key();
            else if (pick < 50 && stored_keys.size() > 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else
                key = KEY_W'($urandom);
        end else begin
            if (pick < 70 && stored_keys.size() > 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (pick < 85)
                key = crowded_key();
            else
                key = KEY_W'($urandom);
        end
        offer_beat(kind, key, PAY_W'($urandom));
    endtask

    // stimulus and verdict
    initial begin
        int n;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_kind     = KIND_INSERT;
        i_key      = '0;
        i_payload  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, lowest and highest keys and payloads
        offer_beat(KIND_LOOKUP, chain_key(0), 16'h0000);
        offer_beat(KIND_INSERT, '0, 16'h0000);
        offer_beat(KIND_LOOKUP, '0, 16'hFFFF);
        offer_beat(KIND_INSERT, {KEY_W{1'b1}}, 16'hFFFF);
        offer_beat(KIND_LOOKUP, {KEY_W{1'b1}}, 16'h0000);
        // build one bucket: new head, smaller head, equal to head, tail, duplicate
        offer_beat(KIND_INSERT, chain_key(10), 16'h0001);
        offer_beat(KIND_INSERT, chain_key(3), 16'h0002);
        offer_beat(KIND_INSERT, chain_key(3), 16'h0003);
        offer_beat(KIND_INSERT, chain_key(20), 16'h0004);
        offer_beat(KIND_INSERT, chain_key(10), 16'h0005);
        offer_beat(KIND_INSERT, chain_key(0), 16'h0006);
        offer_beat(KIND_INSERT, chain_key(15), 16'h0007);
        offer_beat(KIND_INSERT, chain_key(30), 16'h0008);
        // bucket now full, this insert is dropped
        offer_beat(KIND_INSERT, chain_key(1), 16'h0009);
        // duplicates return the first in bucket order; misses in a full bucket
        offer_beat(KIND_LOOKUP, chain_key(3), 16'h0000);
        offer_beat(KIND_LOOKUP, chain_key(10), 16'h0000);
        offer_beat(KIND_LOOKUP, chain_key(30), 16'h0000);
        offer_beat(KIND_LOOKUP, chain_key(0), 16'h0000);
        offer_beat(KIND_LOOKUP, chain_key(2), 16'h0000);
        offer_beat(KIND_LOOKUP, chain_key(1), 16'h0000);
        // miss in a bucket that holds a different key
        offer_beat(KIND_LOOKUP, KEY_W'(32'h7FFF_FFC0), 16'hFFFF);

        for (n = 0; n < RANDOM_OPS; n++) begin
            // switch between stretches with and without idle gaps
            if (n % 150 == 0) sender_calm = ($urandom_range(0, 2) == 0);
            offer_random_op();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // let the pending count take in the last accepted beat before waiting on it
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** chained_hash_table_insert_lookup: PASSED **");
        else
            $display("** chained_hash_table_insert_lookup: FAILED **");
        $finish;
    end

    // output side: random stall before each beat, calm stretches, and two long
    // hold-offs during which the sender keeps offering so the block backs up
    initial begin
        int wait_cycles;
        int beats;
        beats       = 0;
        i_out_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 120 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
            if (beats == 300 || beats == 1000)
                wait_cycles = HOLD_OFF;
            else
                wait_cycles = receiver_calm ? 0 : $urandom_range(0, 4);
            if (wait_cycles > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (wait_cycles - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            beats++;
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** chained_hash_table_insert_lookup: FAILED **");
        $finish;
    end

endmodule
